// ===== src/es2cal_pkg.sv =====
package es2cal_pkg;

  // datapath operations issued by the controller
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_LOAD_DAY   = 4'd1;
  localparam logic [3:0] OP_DAY_Q      = 4'd2;
  localparam logic [3:0] OP_SPLIT      = 4'd3;
  localparam logic [3:0] OP_HOUR_Q     = 4'd4;
  localparam logic [3:0] OP_HOUR_R     = 4'd5;
  localparam logic [3:0] OP_MIN_Q      = 4'd6;
  localparam logic [3:0] OP_MIN_R      = 4'd7;
  localparam logic [3:0] OP_YEAR_STEP  = 4'd8;
  localparam logic [3:0] OP_MONTH_INIT = 4'd9;
  localparam logic [3:0] OP_MONTH_STEP = 4'd10;
  localparam logic [3:0] OP_PUBLISH    = 4'd11;

  localparam logic signed [16:0] ZONE_RESET = 17'sd28800;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

endpackage

// ===== src/es2cal_ctrl.sv =====
module es2cal_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  es2cal_pkg::sts_t sts,
  output es2cal_pkg::cmd_t cmd
);
  import es2cal_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DAY_Q  = 4'd1;
  localparam logic [3:0] S_SPLIT  = 4'd2;
  localparam logic [3:0] S_HOUR_Q = 4'd3;
  localparam logic [3:0] S_HOUR_R = 4'd4;
  localparam logic [3:0] S_MIN_Q  = 4'd5;
  localparam logic [3:0] S_MIN_R  = 4'd6;
  localparam logic [3:0] S_YEAR   = 4'd7;
  localparam logic [3:0] S_MONTH  = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD_DAY;
          state_nxt = S_DAY_Q;
        end
      end
      S_DAY_Q: begin
        cmd.op    = OP_DAY_Q;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = S_HOUR_Q;
      end
      S_HOUR_Q: begin
        cmd.op    = OP_HOUR_Q;
        state_nxt = S_HOUR_R;
      end
      S_HOUR_R: begin
        cmd.op    = OP_HOUR_R;
        state_nxt = S_MIN_Q;
      end
      S_MIN_Q: begin
        cmd.op    = OP_MIN_Q;
        state_nxt = S_MIN_R;
      end
      S_MIN_R: begin
        cmd.op    = OP_MIN_R;
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_done) begin
          cmd.op    = OP_MONTH_INIT;
          state_nxt = S_MONTH;
        end else begin
          cmd.op = OP_YEAR_STEP;
        end
      end
      S_MONTH: begin
        if (sts.month_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op = OP_MONTH_STEP;
        end
      end
      S_FINISH: begin
        // hand over only once the output register is free or draining
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_day: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DAY_Q))
    else $error("accepted request did not start the day split");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && out_stall) |=>
      (state_r == S_FINISH && out_valid_r))
    else $error("finished result left while output register was stalled");

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r <= S_FINISH))
    else $error("controller in an undefined state");

endmodule

// ===== src/es2cal_dp.sv =====
module es2cal_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  es2cal_pkg::cmd_t    cmd,
  output es2cal_pkg::sts_t    sts,
  input  logic                cfg_we,
  input  logic signed [16:0]  cfg_zone_offset_seconds,
  input  logic signed [32:0]  in_epoch_seconds,
  output logic [5:0]          out_second_of_minute,
  output logic [5:0]          out_minute_of_hour,
  output logic [4:0]          out_hour_of_day,
  output logic [4:0]          out_day_of_month,
  output logic [3:0]          out_month_index,
  output logic [7:0]          out_years_since_1900,
  output logic [2:0]          out_weekday,
  output logic [8:0]          out_day_of_year
);
  import es2cal_pkg::*;

  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic [10:0] DAYS_PER_FOUR = 11'd1461;
  localparam logic [7:0]  BASE_YEAR     = 8'd70;

  // reciprocals, exact over the operand ranges seen here:
  // days = (t >> 7) / 675, hour = (sod >> 4) / 225, minute = (soh >> 2) / 15
  localparam logic [52:0] RECIP_DAY   = 53'd101806633;  // ceil(2^36 / 675)
  localparam logic [25:0] RECIP_HOUR  = 26'd9321;       // ceil(2^21 / 225)
  localparam logic [19:0] RECIP_MIN   = 20'd1093;       // ceil(2^14 / 15)
  localparam logic [32:0] RECIP_BLOCK = 33'd91868;      // ceil(2^27 / 1461)

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd1:                      month_len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  // 8 == 1 mod 7, so octal digits can be summed and folded
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s;
    logic [3:0] f1;
    logic [2:0] f2;
    s  = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    f1 = 4'(s[5:3]) + 4'(s[2:0]);
    f2 = 3'(f1[3]) + f1[2:0];
    mod7 = (f2 == 3'd7) ? 3'd0 : f2;
  endfunction

  logic signed [16:0] offset_r;

  logic [32:0] t_r;
  logic [15:0] days_r;
  logic [16:0] sod_r;
  logic [11:0] soh_r;
  logic [5:0]  blk_r;
  logic [2:0]  wday_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r, sec_r;
  logic [7:0]  year_r;
  logic [10:0] ydays_r;
  logic [8:0]  yday_r;
  logic [8:0]  mday_r;
  logic [3:0]  mon_r;
  logic        feb29_r;

  logic [33:0] sum;
  logic [32:0] t;
  logic        leap;
  logic [8:0]  year_len;
  logic [8:0]  day1;
  logic        m_leap;
  logic [4:0]  cur_len;

  assign sum = {in_epoch_seconds[32], in_epoch_seconds}
             + {{17{offset_r[16]}}, offset_r};
  assign t   = sum[33] ? 33'd0 : sum[32:0];

  assign leap     = (year_r[1:0] == 2'd0);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign day1     = ydays_r[8:0] + 9'd1;
  assign m_leap   = leap;
  assign cur_len  = month_len(mon_r);

  assign sts.year_done  = (ydays_r < {2'b00, year_len});
  assign sts.month_done = feb29_r || (mon_r == 4'd11) || ({4'b0000, cur_len} >= mday_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= ZONE_RESET;
    end else if (cfg_we) begin
      offset_r <= cfg_zone_offset_seconds;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_DAY: begin
        t_r <= t;
      end
      OP_DAY_Q: begin
        days_r <= 16'((53'(t_r[32:7]) * RECIP_DAY) >> 36);
      end
      OP_SPLIT: begin
        // remainders fit their narrow widths, so the products wrap harmlessly
        sod_r  <= t_r[16:0] - 17'(days_r) * SEC_PER_DAY;
        wday_r <= mod7(days_r + 16'd4);
        blk_r  <= 6'((33'(days_r) * RECIP_BLOCK) >> 27);
      end
      OP_HOUR_Q: begin
        hour_r  <= 5'((26'(sod_r[16:4]) * RECIP_HOUR) >> 21);
        year_r  <= {blk_r, 2'b00} + BASE_YEAR;
        ydays_r <= days_r[10:0] - 11'(blk_r) * DAYS_PER_FOUR;
      end
      OP_HOUR_R: begin
        soh_r <= sod_r[11:0] - 12'(hour_r) * SEC_PER_HOUR;
      end
      OP_MIN_Q: begin
        min_r <= 6'((20'(soh_r[11:2]) * RECIP_MIN) >> 14);
      end
      OP_MIN_R: begin
        sec_r <= soh_r[5:0] - 6'(min_r) * SEC_PER_MIN;
      end
      OP_YEAR_STEP: begin
        ydays_r <= ydays_r - {2'b00, year_len};
        year_r  <= year_r + 8'd1;
      end
      OP_MONTH_INIT: begin
        yday_r  <= ydays_r[8:0];
        mon_r   <= 4'd0;
        feb29_r <= m_leap && (day1 == 9'd60);
        // past february 29 the common-year table applies after one day back
        mday_r  <= (m_leap && day1 > 9'd60) ? day1 - 9'd1 : day1;
      end
      OP_MONTH_STEP: begin
        mday_r <= mday_r - {4'b0000, cur_len};
        mon_r  <= mon_r + 4'd1;
      end
      OP_PUBLISH: begin
        out_second_of_minute <= sec_r;
        out_minute_of_hour   <= min_r;
        out_hour_of_day      <= hour_r;
        out_day_of_month     <= feb29_r ? 5'd29 : mday_r[4:0];
        out_month_index      <= feb29_r ? 4'd1 : mon_r;
        out_years_since_1900 <= year_r;
        out_weekday          <= wday_r;
        out_day_of_year      <= yday_r;
      end
      default: begin
      end
    endcase
  end

  a_min_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MIN_Q) |-> (soh_r < SEC_PER_HOUR))
    else $error("remainder after hour split too large");

  a_year_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MONTH_INIT) |-> (ydays_r < 11'd366))
    else $error("day of year out of range after year correction");

  a_mday_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUBLISH) |->
      (feb29_r || (mday_r != 9'd0 && mday_r <= 9'd31 && mon_r <= 4'd11)))
    else $error("month walk ended with an invalid day");

endmodule

// ===== src/epoch_seconds_to_calendar_unit.sv =====
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_epoch_seconds
// out       output     out_valid/out_stall out_second_of_minute .. out_day_of_year
// cfg       input      cfg_valid/cfg_ready cfg_zone_offset_seconds
//
// one request at a time: from acceptance to the result register it runs six fixed
// reciprocal-multiply and remainder steps, a year loop (up to 3 corrections), a month loop
// (up to 11 steps) and one hand-over
// in_stall drops again the cycle after the result is handed to the output register
// a result waiting under out_stall holds; the next request is still taken meanwhile
// reset (synchronous, active low) clears control and sets the zone offset to 28800
module epoch_seconds_to_calendar_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [32:0] in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_second_of_minute,
  output logic [5:0]         out_minute_of_hour,
  output logic [4:0]         out_hour_of_day,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month_index,
  output logic [7:0]         out_years_since_1900,
  output logic [2:0]         out_weekday,
  output logic [8:0]         out_day_of_year,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [16:0] cfg_zone_offset_seconds
);
  import es2cal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  es2cal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  es2cal_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_we                  (cfg_valid && cfg_ready),
    .cfg_zone_offset_seconds (cfg_zone_offset_seconds),
    .in_epoch_seconds        (in_epoch_seconds),
    .out_second_of_minute    (out_second_of_minute),
    .out_minute_of_hour      (out_minute_of_hour),
    .out_hour_of_day         (out_hour_of_day),
    .out_day_of_month        (out_day_of_month),
    .out_month_index         (out_month_index),
    .out_years_since_1900    (out_years_since_1900),
    .out_weekday             (out_weekday),
    .out_day_of_year         (out_day_of_year)
  );

endmodule
